FILE: sv/rrts_pkg.sv
// Shared types, codes and helpers for the round-robin thread scheduler.
`default_nettype none

package rrts_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = 4;
  localparam int ST_W      = 3;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

  // slot state codes
  localparam logic [ST_W-1:0] ST_EMPTY   = 3'd0;
  localparam logic [ST_W-1:0] ST_READY   = 3'd1;
  localparam logic [ST_W-1:0] ST_RUNNING = 3'd2;
  localparam logic [ST_W-1:0] ST_BLOCKED = 3'd3;
  localparam logic [ST_W-1:0] ST_EXITED  = 3'd4;

  // operation codes
  localparam logic [1:0] FN_WRITE = 2'd0;
  localparam logic [1:0] FN_SCHED = 2'd1;
  localparam logic [1:0] FN_SET   = 2'd2;
  localparam logic [1:0] FN_EXIT  = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_READY = 2'd1;
  localparam logic [1:0] STAT_NO_CUR   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SELECT,
    S_ACT,
    S_DONE
  } fsm_t;

  // one read and one write port request to the slot table
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [ST_W-1:0]   wr_data;
  } tbl_req_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
    logic [SLOT_W-1:0] r;
    if (p == SLOT_W'(NUM_SLOTS - 1)) r = '0;
    else r = p + SLOT_W'(1);
    return r;
  endfunction

  function automatic logic st_runnable(input logic [ST_W-1:0] s);
    return (s != ST_EMPTY) && (s != ST_BLOCKED) && (s != ST_EXITED);
  endfunction

endpackage

`default_nettype wire

FILE: sv/rrts_slot_table.sv
// Slot state table: synchronous RAM with per-entry valid bits for reset-to-empty.
`default_nettype none

module rrts_slot_table
  import rrts_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire tbl_req_t        req,
  output logic [ST_W-1:0]      rd_data
);

  logic [ST_W-1:0] mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld_r;
  logic [ST_W-1:0] mem_q_r;
  logic vld_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (req.wr_en) vld_r[req.wr_addr] <= 1'b1;
      if (req.rd_en) vld_q_r <= vld_r[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) mem[req.wr_addr] <= req.wr_data;
    if (req.rd_en) mem_q_r <= mem[req.rd_addr];
  end

  // never-written entries read as empty
  assign rd_data = vld_q_r ? mem_q_r : ST_EMPTY;

endmodule

`default_nettype wire

FILE: sv/round_robin_thread_scheduler_core.sv
// Top level of the round-robin thread scheduler: sequencer, current pointer, result word.
`default_nettype none

// Round-robin thread scheduler. Sixteen thread slots each hold a state
// (empty, ready, running, blocked, exited) in a small synchronous RAM with a
// registered read; a current-thread pointer lives in flops. Every accepted
// input word (write slot state, schedule next, set current, exit current then
// schedule) yields exactly one result word with a status, the current thread
// and whether it is runnable. One word is in flight at a time: in_stall is
// high from acceptance until the result is loaded into the output register,
// and a finished result may wait there while the next word is taken. The
// schedule and exit words run a scan that reads one slot per cycle, up to
// 16 slots, through the single RAM read port. Reset clears all slots to
// empty at once through per-slot valid bits, so no clearing pass is needed.
module round_robin_thread_scheduler_core
  import rrts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_func,
  input  wire logic [SLOT_W-1:0] in_slot_index,
  input  wire logic              in_slot_none,
  input  wire logic [ST_W-1:0]   in_new_state,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_status,
  output logic                   out_current_valid,
  output logic [SLOT_W-1:0]      out_current_slot,
  output logic                   out_runnable
);

  fsm_t state_r, state_nxt;

  // latched input word
  logic [1:0]        func_r, func_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic              none_r, none_nxt;
  logic [ST_W-1:0]   ns_r, ns_nxt;

  // current-thread pointer
  logic              cur_valid_r, cur_valid_nxt;
  logic [SLOT_W-1:0] cur_slot_r, cur_slot_nxt;
  logic [ST_W-1:0]   cur_st_r, cur_st_nxt;   // state of current slot, read at dispatch

  // scan
  logic [SLOT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0]  iss_cnt_r, iss_cnt_nxt;
  logic [SLOT_W-1:0] prev_pos_r, prev_pos_nxt;
  logic              prev_vld_r, prev_vld_nxt;
  logic [SLOT_W-1:0] tgt_r, tgt_nxt;
  logic              hit_r, hit_nxt;

  // result being built
  logic [1:0]        status_r, status_nxt;
  logic              run_r, run_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic              out_cv_r, out_cv_nxt;
  logic [SLOT_W-1:0] out_cs_r, out_cs_nxt;
  logic              out_run_r, out_run_nxt;

  tbl_req_t          req;
  logic [ST_W-1:0]   rd_data;
  logic              idx_ok;
  logic              ns_ok;
  logic [ST_W-1:0]   sel_st;

  rrts_slot_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  assign idx_ok = ({1'b0, idx_r} < (SLOT_W + 1)'(NUM_SLOTS));
  assign ns_ok  = (ns_r <= ST_EXITED);
  // a slot found by the scan is known ready; otherwise use the target read
  assign sel_st = hit_r ? ST_READY : rd_data;

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    idx_nxt        = idx_r;
    none_nxt       = none_r;
    ns_nxt         = ns_r;
    cur_valid_nxt  = cur_valid_r;
    cur_slot_nxt   = cur_slot_r;
    cur_st_nxt     = cur_st_r;
    pos_nxt        = pos_r;
    iss_cnt_nxt    = iss_cnt_r;
    prev_pos_nxt   = prev_pos_r;
    prev_vld_nxt   = prev_vld_r;
    tgt_nxt        = tgt_r;
    hit_nxt        = hit_r;
    status_nxt     = status_r;
    run_nxt        = run_r;
    out_status_nxt = out_status_r;
    out_cv_nxt     = out_cv_r;
    out_cs_nxt     = out_cs_r;
    out_run_nxt    = out_run_r;
    out_valid_nxt  = out_valid_r && out_stall;
    req            = '0;
    in_stall       = (state_r != S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt    = in_func;
          idx_nxt     = in_slot_index;
          none_nxt    = in_slot_none;
          ns_nxt      = in_new_state;
          req.rd_en   = 1'b1;
          req.rd_addr = cur_slot_r;
          state_nxt   = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        // rd_data holds the current slot's state here
        cur_st_nxt   = rd_data;
        status_nxt   = STAT_OK;
        run_nxt      = 1'b0;
        prev_vld_nxt = 1'b0;
        iss_cnt_nxt  = '0;
        hit_nxt      = 1'b0;
        case (func_r)
          FN_WRITE: begin
            if (idx_ok && ns_ok) begin
              req.wr_en   = 1'b1;
              req.wr_addr = idx_r;
              req.wr_data = ns_r;
            end
            if (idx_ok && ns_ok && idx_r == cur_slot_r)
              run_nxt = cur_valid_r && st_runnable(ns_r);
            else
              run_nxt = cur_valid_r && st_runnable(rd_data);
            state_nxt = S_DONE;
          end
          FN_SCHED: begin
            pos_nxt   = (cur_valid_r && rd_data != ST_EMPTY) ? next_slot(cur_slot_r) : '0;
            state_nxt = S_SCAN;
          end
          FN_SET: begin
            if (none_r) begin
              if (cur_valid_r && rd_data == ST_RUNNING) begin
                req.wr_en   = 1'b1;
                req.wr_addr = cur_slot_r;
                req.wr_data = ST_READY;
              end
              cur_valid_nxt = 1'b0;
              cur_slot_nxt  = '0;
              state_nxt     = S_DONE;
            end else if (idx_ok) begin
              req.rd_en   = 1'b1;
              req.rd_addr = idx_r;
              tgt_nxt     = idx_r;
              state_nxt   = S_SELECT;
            end else begin
              run_nxt   = cur_valid_r && st_runnable(rd_data);
              state_nxt = S_DONE;
            end
          end
          FN_EXIT: begin
            if (!cur_valid_r) begin
              status_nxt = STAT_NO_CUR;
              state_nxt  = S_DONE;
            end else begin
              req.wr_en   = 1'b1;
              req.wr_addr = cur_slot_r;
              req.wr_data = ST_EXITED;
              cur_st_nxt  = ST_EXITED;
              pos_nxt     = next_slot(cur_slot_r);
              state_nxt   = S_SCAN;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end

      S_SCAN: begin
        // one read issued per cycle, result checked in the next cycle
        if (prev_vld_r && rd_data == ST_READY) begin
          tgt_nxt   = prev_pos_r;
          hit_nxt   = 1'b1;
          state_nxt = S_SELECT;
        end else if (iss_cnt_r != CNT_W'(NUM_SLOTS)) begin
          req.rd_en    = 1'b1;
          req.rd_addr  = pos_r;
          prev_pos_nxt = pos_r;
          prev_vld_nxt = 1'b1;
          pos_nxt      = next_slot(pos_r);
          iss_cnt_nxt  = iss_cnt_r + CNT_W'(1);
        end else begin
          cur_valid_nxt = 1'b0;
          cur_slot_nxt  = '0;
          status_nxt    = STAT_NO_READY;
          run_nxt       = 1'b0;
          state_nxt     = S_DONE;
        end
      end

      S_SELECT: begin
        if (sel_st == ST_EMPTY) begin
          // empty slot holds no thread: same as selecting none
          if (cur_valid_r && cur_st_r == ST_RUNNING) begin
            req.wr_en   = 1'b1;
            req.wr_addr = cur_slot_r;
            req.wr_data = ST_READY;
          end
          cur_valid_nxt = 1'b0;
          cur_slot_nxt  = '0;
          run_nxt       = 1'b0;
          state_nxt     = S_DONE;
        end else begin
          if (cur_valid_r && cur_slot_r != tgt_r && cur_st_r == ST_RUNNING) begin
            req.wr_en   = 1'b1;
            req.wr_addr = cur_slot_r;
            req.wr_data = ST_READY;
          end
          cur_valid_nxt = 1'b1;
          cur_slot_nxt  = tgt_r;
          run_nxt       = st_runnable(sel_st);
          state_nxt     = (sel_st == ST_READY) ? S_ACT : S_DONE;
        end
      end

      S_ACT: begin
        req.wr_en   = 1'b1;
        req.wr_addr = tgt_r;
        req.wr_data = ST_RUNNING;
        state_nxt   = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_cv_nxt     = cur_valid_r;
          out_cs_nxt     = cur_slot_r;
          out_run_nxt    = run_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_valid_r <= 1'b0;
      cur_slot_r  <= '0;
      out_valid_r <= 1'b0;
      prev_vld_r  <= 1'b0;
      hit_r       <= 1'b0;
      iss_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_slot_r  <= cur_slot_nxt;
      out_valid_r <= out_valid_nxt;
      prev_vld_r  <= prev_vld_nxt;
      hit_r       <= hit_nxt;
      iss_cnt_r   <= iss_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    idx_r        <= idx_nxt;
    none_r       <= none_nxt;
    ns_r         <= ns_nxt;
    cur_st_r     <= cur_st_nxt;
    pos_r        <= pos_nxt;
    prev_pos_r   <= prev_pos_nxt;
    tgt_r        <= tgt_nxt;
    status_r     <= status_nxt;
    run_r        <= run_nxt;
    out_status_r <= out_status_nxt;
    out_cv_r     <= out_cv_nxt;
    out_cs_r     <= out_cs_nxt;
    out_run_r    <= out_run_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_current_valid = out_cv_r;
  assign out_current_slot  = out_cs_r;
  assign out_runnable      = out_run_r;

  // checks
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DISPATCH))
    else $error("accepted word did not go to dispatch");

  a_none_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !cur_valid_r |-> (cur_slot_r == '0))
    else $error("no current thread but slot pointer nonzero");

  a_run_needs_cur: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_run_r) |-> out_cv_r)
    else $error("runnable reported without a current thread");

  a_fail_clears_cur: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == STAT_NO_READY || out_status_r == STAT_NO_CUR))
      |-> !out_cv_r)
    else $error("failure status with a current thread");

endmodule

`default_nettype wire

FILE: sim/tb_round_robin_thread_scheduler_core.sv
// Self-checking testbench for the round-robin thread scheduler core.
module tb_round_robin_thread_scheduler_core;
  import rrts_pkg::*;

  // Run limits. The cycle limit allows several times the slowest correct word,
  // counting idle on the send side, the scan, and stall on the result side.
  localparam int RANDOM_WORDS = 1150;
  localparam int DRAIN_CYCLES = 30;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int MAX_WAIT     = 17;

  // One result word as the block reports it.
  typedef struct packed {
    logic [1:0]        status;
    logic              cur_valid;
    logic [SLOT_W-1:0] cur_slot;
    logic              runnable;
  } sched_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_func = FN_WRITE;
  logic [SLOT_W-1:0] in_slot_index = '0;
  logic              in_slot_none = 1'b0;
  logic [ST_W-1:0]   in_new_state = ST_EMPTY;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_status;
  logic              out_current_valid;
  logic [SLOT_W-1:0] out_current_slot;
  logic              out_runnable;

  // Expected result words, oldest first.
  sched_result_t pending_results[$];

  // Predictor copy of the slot table and the current-thread pointer.
  logic [ST_W-1:0]   thread_state [NUM_SLOTS];
  logic              cur_on;
  logic [SLOT_W-1:0] cur_idx;

  int  err_count = 0;
  int  cycle_count = 0;
  int  result_hold = 0;
  // When set, neither side idles: back-to-back stretches.
  bit  quiet_stretch = 1'b0;

  round_robin_thread_scheduler_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_slot_index     (in_slot_index),
    .in_slot_none      (in_slot_none),
    .in_new_state      (in_new_state),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_current_valid (out_current_valid),
    .out_current_slot  (out_current_slot),
    .out_runnable      (out_runnable)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Idle cycles per word for either side; about a third of the words get none.
  function automatic int pick_wait();
    if (quiet_stretch || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    err_count++;
    if (err_count <= 200)
      $display("mismatch @%0d: %s got %0h expected %0h", cycle_count, what, got, want);
  endtask

  // ---------------------------------------------------------------- predictor

  // Switch the current pointer; an empty slot holds no thread, so selecting
  // it means selecting none. A running old thread drops back to ready.
  function automatic void switch_thread(input logic want_on, input logic [SLOT_W-1:0] slot);
    logic on;
    on = want_on;
    if (on && thread_state[slot] == ST_EMPTY) on = 1'b0;
    if (cur_on && (!on || cur_idx != slot) && thread_state[cur_idx] == ST_RUNNING)
      thread_state[cur_idx] = ST_READY;
    cur_on  = on;
    cur_idx = on ? slot : '0;
    if (cur_on && thread_state[cur_idx] == ST_READY)
      thread_state[cur_idx] = ST_RUNNING;
  endfunction

  // Round-robin scan from the slot after the current one. An emptied current
  // slot restarts the scan at slot 0.
  function automatic logic [1:0] pick_next_ready();
    int start;
    int i;
    logic [SLOT_W-1:0] k;
    start = 0;
    if (cur_on && thread_state[cur_idx] != ST_EMPTY) start = int'(cur_idx) + 1;
    for (i = 0; i < NUM_SLOTS; i++) begin
      k = SLOT_W'((start + i) % NUM_SLOTS);
      if (thread_state[k] == ST_READY) begin
        switch_thread(1'b1, k);
        return STAT_OK;
      end
    end
    // nothing ready: drop the pointer, old running thread keeps its state
    cur_on  = 1'b0;
    cur_idx = '0;
    return STAT_NO_READY;
  endfunction

  function automatic sched_result_t predict_word(input logic [1:0] fn,
                                                 input logic [SLOT_W-1:0] idx,
                                                 input logic no_cur,
                                                 input logic [ST_W-1:0] ns);
    sched_result_t r;
    logic [ST_W-1:0] cs;
    r.status = STAT_OK;
    case (fn)
      FN_WRITE: if (ns <= ST_EXITED) thread_state[idx] = ns;
      FN_SCHED: r.status = pick_next_ready();
      FN_SET: begin
        if (no_cur) switch_thread(1'b0, '0);
        else switch_thread(1'b1, idx);
      end
      FN_EXIT: begin
        if (!cur_on) begin
          r.status = STAT_NO_CUR;
        end else begin
          thread_state[cur_idx] = ST_EXITED;
          r.status = pick_next_ready();
        end
      end
    endcase
    cs          = thread_state[cur_idx];
    r.cur_valid = cur_on;
    r.cur_slot  = cur_on ? cur_idx : '0;
    r.runnable  = cur_on && cs != ST_EMPTY && cs != ST_BLOCKED && cs != ST_EXITED;
    return r;
  endfunction

  // ----------------------------------------------------------------- driving

  // Sends one word and records its expected result once it is taken.
  // Called and returns at a rising edge; in_valid gets one update per edge.
  task automatic send_word(input logic [1:0] fn, input logic [SLOT_W-1:0] idx,
                           input logic no_cur, input logic [ST_W-1:0] ns);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= fn;
    in_slot_index <= idx;
    in_slot_none  <= no_cur;
    in_new_state  <= ns;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_word(fn, idx, no_cur, ns));
  endtask

  // ---------------------------------------------------------------- checking

  // Result side: takes words, compares them in order, and stalls a random
  // number of cycles against each word while it is on offer.
  always @(posedge clk) begin : result_monitor
    sched_result_t seen;
    sched_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen = '{out_status, out_current_valid, out_current_slot, out_runnable};
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing pending", 8'(seen), 8'h0);
      end else begin
        want = pending_results.pop_front();
        if (seen.status !== want.status)
          report_mismatch("status", 8'(seen.status), 8'(want.status));
        if (seen.cur_valid !== want.cur_valid)
          report_mismatch("current_valid", 8'(seen.cur_valid), 8'(want.cur_valid));
        if (seen.cur_slot !== want.cur_slot)
          report_mismatch("current_slot", 8'(seen.cur_slot), 8'(want.cur_slot));
        if (seen.runnable !== want.runnable)
          report_mismatch("runnable", 8'(seen.runnable), 8'(want.runnable));
      end
      result_hold = pick_wait();
      out_stall <= (result_hold != 0);
    end else if (out_valid && out_stall) begin
      if (result_hold > 0) result_hold--;
      out_stall <= (result_hold != 0);
    end
  end

  // -------------------------------------------------------------- test tasks

  // Fresh table: nothing to schedule, nothing to exit.
  task automatic test_empty_table();
    send_word(FN_SCHED, 4'd0, 1'b0, ST_EMPTY);
    send_word(FN_EXIT, 4'd15, 1'b1, ST_READY);
  endtask

  // Codes above exited leave the table alone.
  task automatic test_bad_state_write();
    send_word(FN_WRITE, 4'd15, 1'b1, 3'd7);
    send_word(FN_WRITE, 4'd0, 1'b0, 3'd5);
  endtask

  // Set-current: to none, to an empty slot, to ready slots, to itself.
  task automatic test_set_current();
    send_word(FN_SET, 4'd9, 1'b1, ST_EMPTY);
    send_word(FN_SET, 4'd3, 1'b0, ST_EMPTY);
    send_word(FN_WRITE, 4'd0, 1'b0, ST_READY);
    send_word(FN_SET, 4'd0, 1'b0, ST_EMPTY);
    send_word(FN_WRITE, 4'd15, 1'b0, ST_READY);
    send_word(FN_SET, 4'd15, 1'b0, ST_EMPTY);
    send_word(FN_SET, 4'd15, 1'b0, ST_BLOCKED);
  endtask

  // Scheduling skips blocked slots and wraps past the top slot.
  task automatic test_round_robin();
    send_word(FN_WRITE, 4'd5, 1'b0, ST_READY);
    send_word(FN_WRITE, 4'd7, 1'b0, ST_BLOCKED);
    send_word(FN_SCHED, 4'd0, 1'b0, ST_EMPTY);
    send_word(FN_SCHED, 4'd0, 1'b0, ST_EMPTY);
    send_word(FN_SCHED, 4'd0, 1'b0, ST_EMPTY);
  endtask

  // Exit until nothing ready remains; last one reports no ready thread.
  task automatic test_exit_current();
    send_word(FN_EXIT, 4'd0, 1'b0, ST_EMPTY);
    send_word(FN_EXIT, 4'd0, 1'b0, ST_EMPTY);
    send_word(FN_EXIT, 4'd0, 1'b0, ST_EMPTY);
  endtask

  // Current slot written empty: pointer stays, not runnable, scan from 0.
  task automatic test_current_emptied();
    send_word(FN_WRITE, 4'd9, 1'b0, ST_RUNNING);
    send_word(FN_SET, 4'd9, 1'b0, ST_EMPTY);
    send_word(FN_WRITE, 4'd9, 1'b0, ST_EMPTY);
    send_word(FN_WRITE, 4'd2, 1'b0, ST_READY);
    send_word(FN_SCHED, 4'd0, 1'b0, ST_EMPTY);
  endtask

  // Dropping a running current thread makes it ready again.
  task automatic test_drop_running();
    send_word(FN_SET, 4'd0, 1'b1, ST_EMPTY);
  endtask

  // Mostly well-formed traffic that keeps a populated table, some noise.
  task automatic test_random_traffic(input int n_words);
    int k;
    int pick;
    int sp;
    logic [ST_W-1:0] ns;
    for (k = 0; k < n_words; k++) begin
      if (k % 50 == 0) quiet_stretch = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      sp   = $urandom_range(0, 99);
      if (sp < 40)      ns = ST_READY;
      else if (sp < 55) ns = ST_BLOCKED;
      else if (sp < 67) ns = ST_EMPTY;
      else if (sp < 78) ns = ST_EXITED;
      else if (sp < 90) ns = ST_RUNNING;
      else              ns = ST_W'($urandom_range(5, 7));
      if (pick < 5)
        send_word(2'($urandom_range(0, 3)), SLOT_W'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)), ST_W'($urandom_range(0, 7)));
      else if (pick < 45)
        send_word(FN_WRITE, SLOT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), ns);
      else if (pick < 70)
        send_word(FN_SCHED, SLOT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), ns);
      else if (pick < 85)
        send_word(FN_EXIT, SLOT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), ns);
      else
        send_word(FN_SET, SLOT_W'($urandom_range(0, 15)),
                  1'($urandom_range(0, 3) == 0), ns);
    end
    quiet_stretch = 1'b0;
  endtask

  // -------------------------------------------------------------- main flow

  initial begin : main_flow
    int s;
    for (s = 0; s < NUM_SLOTS; s++) thread_state[s] = ST_EMPTY;
    cur_on  = 1'b0;
    cur_idx = '0;

    // synchronous reset, held before the tests start
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_bad_state_write();
    test_set_current();
    test_round_robin();
    test_exit_current();
    test_current_emptied();
    test_drop_running();
    test_random_traffic(RANDOM_WORDS);
    in_valid <= 1'b0;

    // drain; any stray word after this is flagged by the monitor
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/rrts_pkg.sv
sv/rrts_slot_table.sv
sv/round_robin_thread_scheduler_core.sv
sim/tb_round_robin_thread_scheduler_core.sv
